@@ sv/cht_pkg.sv @@
`timescale 1ns / 1ps

package cht_pkg;

   localparam int SLOTS_DEF     = 1024;
   localparam int MAX_KICKS_DEF = 64;

   localparam int KEY_W  = 31;
   localparam int SKEY_W = 32;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 11;
   localparam int PROD_W = 35;
   localparam int MUL2   = 11;

   localparam logic [SKEY_W-1:0] KEY_EMPTY   = '0;
   localparam logic [SKEY_W-1:0] KEY_DELETED = '1;

   localparam logic [1:0] KIND_GET = 2'd0;
   localparam logic [1:0] KIND_PUT = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] found_value;
      logic [CNT_W-1:0]        entry_count;
      logic [KEY_W-1:0]        homeless_key;
      logic signed [VAL_W-1:0] homeless_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH_A,
      S_HASH_B,
      S_RD_A,
      S_RD_B,
      S_LATCH,
      S_FIND,
      S_PLACE,
      S_DONE
   } state_type;

endpackage

@@ sv/cht_ram.sv @@
`timescale 1ns / 1ps

module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/cht_mod.sv @@
`timescale 1ns / 1ps

module cht_mod
   import cht_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [PROD_W-1:0]        operand,
   output logic                     done,
   output logic [$clog2(SLOTS)-1:0] result
);

   localparam int AW = $clog2(SLOTS);

   logic [AW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;

   // SLOTS is a power of two, so the remainder is the low address bits
   always_comb begin
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = AW'(operand);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

@@ sv/cuckoo_hash_table.sv @@
`timescale 1ns / 1ps

// Two-choice cuckoo key/value table.
// req channel: one word per operation (lookup, insert/update, delete) with
// valid/stall; req_stall is high from acceptance until the result is loaded.
// rsp channel: exactly one result word per request, held in an output
// register; the next request is taken while that word still waits.
// Both slot indices come from one shared remainder unit, one after the
// other (SLOTS a power of two); slot reads go through registered RAM ports.
// States from acceptance to the result word, each path ending in S_DONE:
//   lookup / delete / update : hash A, hash B, read A, read B, latch, find
//   new key                  : the same, then place; an eviction goes
//                              back to hash A, at most MAX_KICKS evictions
//   zero key or unused kind  : straight to S_DONE
// After reset the key store is swept to empty, with req_stall high. A
// stalled rsp word holds; a finished operation waits in place until the
// output register is free.
module cuckoo_hash_table
   import cht_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_KICKS = MAX_KICKS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int KW = $clog2(MAX_KICKS + 1);

   state_type state_ff, state_in;

   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  cur_key_ff, cur_key_in;
   logic [VAL_W-1:0]  cur_val_ff, cur_val_in;
   logic [AW-1:0]     a_ff, a_in, b_ff, b_in;
   logic [SKEY_W-1:0] ka_ff, ka_in, kb_ff, kb_in;
   logic [VAL_W-1:0]  va_ff, va_in, vb_ff, vb_in;
   logic [KEY_W-1:0]  tracker_ff, tracker_in;
   logic [KW-1:0]     kicks_ff, kicks_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     clr_ff, clr_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              mod_start, mod_done;
   logic [PROD_W-1:0] mod_operand;
   logic [AW-1:0]     mod_result;

   logic              key_we, val_we;
   logic [AW-1:0]     key_waddr, val_waddr, rd_addr;
   logic [SKEY_W-1:0] key_wdata, key_rd;
   logic [VAL_W-1:0]  val_wdata, val_rd;

   logic [SKEY_W-1:0] cur_skey;
   logic              hit_a, hit_b, free_a, free_b;

   cht_mod #(.SLOTS(SLOTS)) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .operand (mod_operand),
      .done    (mod_done),
      .result  (mod_result)
   );

   cht_ram #(.WIDTH(SKEY_W), .DEPTH(SLOTS)) u_keys (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   cht_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_vals (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign cur_skey = {1'b0, cur_key_ff};
   assign hit_a    = (ka_ff == cur_skey);
   assign hit_b    = (kb_ff == cur_skey);
   assign free_a   = (ka_ff == KEY_EMPTY) || (ka_ff == KEY_DELETED);
   assign free_b   = (kb_ff == KEY_EMPTY) || (kb_ff == KEY_DELETED);
   assign rd_addr  = (state_ff == S_RD_A) ? a_ff : b_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_key_in   = cur_key_ff;
      cur_val_in   = cur_val_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      tracker_in   = tracker_ff;
      kicks_in     = kicks_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mod_start    = 1'b0;
      mod_operand  = PROD_W'(cur_key_ff);
      key_we       = 1'b0;
      key_waddr    = a_ff;
      key_wdata    = cur_skey;
      val_we       = 1'b0;
      val_waddr    = a_ff;
      val_wdata    = cur_val_ff;
      req_stall    = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            key_we    = 1'b1;
            key_waddr = clr_ff;
            key_wdata = KEY_EMPTY;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in      = req_data.kind;
               cur_key_in = req_data.key;
               cur_val_in = req_data.item_value;
               res_in     = '0;
               res_in.status = ST_MISS;
               if (req_data.kind == KIND_GET || req_data.kind == KIND_DEL ||
                   req_data.kind == KIND_PUT) begin
                  if (req_data.key == '0) begin
                     if (req_data.kind == KIND_PUT) begin
                        res_in.status         = ST_FAIL;
                        res_in.homeless_value = req_data.item_value;
                     end
                     state_in = S_DONE;
                  end else begin
                     mod_start   = 1'b1;
                     mod_operand = PROD_W'(req_data.key);
                     state_in    = S_HASH_A;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_HASH_A: begin
            if (mod_done) begin
               a_in        = mod_result;
               mod_start   = 1'b1;
               mod_operand = PROD_W'(cur_key_ff) * PROD_W'(MUL2);
               state_in    = S_HASH_B;
            end
         end
         S_HASH_B: begin
            if (mod_done) begin
               b_in     = mod_result;
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
         end
         S_RD_B: begin
            ka_in    = key_rd;
            va_in    = val_rd;
            state_in = S_LATCH;
         end
         S_LATCH: begin
            kb_in    = key_rd;
            vb_in    = val_rd;
            state_in = (op_ff == KIND_PUT && tracker_ff != '0) ? S_PLACE :
                       (op_ff == KIND_PUT && kicks_ff != '0) ? S_PLACE : S_FIND;
         end
         S_FIND: begin
            state_in = S_DONE;
            if (hit_a || hit_b) begin
               res_in.status = ST_OK;
               if (op_ff == KIND_PUT) begin
                  val_we    = 1'b1;
                  val_waddr = hit_a ? a_ff : b_ff;
               end else begin
                  res_in.found_value = hit_a ? va_ff : vb_ff;
                  if (op_ff == KIND_DEL) begin
                     key_we    = 1'b1;
                     key_waddr = hit_a ? a_ff : b_ff;
                     key_wdata = KEY_DELETED;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
            end else if (op_ff == KIND_PUT) begin
               tracker_in = '0;
               kicks_in   = '0;
               state_in   = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = S_DONE;
            if (tracker_ff == cur_key_ff || kicks_ff >= KW'(MAX_KICKS)) begin
               res_in.status         = ST_FAIL;
               res_in.homeless_key   = cur_key_ff;
               res_in.homeless_value = cur_val_ff;
               tracker_in            = '0;
               kicks_in              = '0;
            end else if (free_a || free_b) begin
               key_we        = 1'b1;
               val_we        = 1'b1;
               key_waddr     = free_a ? a_ff : b_ff;
               val_waddr     = free_a ? a_ff : b_ff;
               count_in      = count_ff + 1'b1;
               res_in.status = ST_OK;
               tracker_in    = '0;
               kicks_in      = '0;
            end else begin
               // evict the first-slot occupant and rehash it
               key_we      = 1'b1;
               val_we      = 1'b1;
               cur_key_in  = ka_ff[KEY_W-1:0];
               cur_val_in  = va_ff;
               tracker_in  = tracker_ff ^ cur_key_ff;
               kicks_in    = kicks_ff + 1'b1;
               mod_start   = 1'b1;
               mod_operand = PROD_W'(ka_ff[KEY_W-1:0]);
               state_in    = S_HASH_A;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in             = res_ff;
               rsp_in.entry_count = CNT_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         tracker_ff   <= '0;
         kicks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         tracker_ff   <= tracker_in;
         kicks_ff     <= kicks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cur_key_ff <= cur_key_in;
      cur_val_ff <= cur_val_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      ka_ff      <= ka_in;
      kb_ff      <= kb_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_kicks_bound: assert property (@(posedge clock) disable iff (reset)
      kicks_ff <= KW'(MAX_KICKS))
      else $error("eviction count beyond limit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("live count beyond capacity");

   a_homeless_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_FAIL) |->
         (rsp_data.homeless_key == '0 && rsp_data.homeless_value == '0))
      else $error("homeless pair on a non-failing result");

   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_HASH_A || state_ff == S_HASH_B))
      else $error("remainder result outside hashing");
`endif

endmodule
